// ===== src/humidity_sensor_i2c_reader_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the humidity sensor bus reader
// Concurrent assertion shorthands on the clock/reset of the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_I2C_READER_TOP_DEFINES_SVH
`define HUMIDITY_SENSOR_I2C_READER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HSI2C_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HSI2C_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/hsi2c_pkg.sv =====
// ----------------------------------------------------------------------------
// hsi2c_pkg
// Shared types and constants of the humidity sensor bus reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsi2c_pkg;

   // Register reset values
   localparam logic [7:0]  HALF_PERIOD_RST = 8'd5;
   localparam logic [23:0] CONV_WAIT_RST   = 24'd80000;
   localparam logic [6:0]  DEV_ADDR_RST    = 7'd56;

   localparam int WAIT_BITS_DEF = 24;
   localparam int CONV_WAIT_W   = 24;
   localparam int CSR_DATA_W    = 24;

   // Register indexes
   localparam logic [1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [1:0] CSR_CONV_WAIT   = 2'd1;
   localparam logic [1:0] CSR_DEV_ADDR    = 2'd2;

   // Command codes
   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_INIT    = 2'd1;
   localparam logic [1:0] FUNC_MEASURE = 2'd2;

   // Sensor read-out
   localparam int RX_BYTES  = 6;
   localparam int RAW_W     = 20;
   localparam int FRAC_BITS = 20;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [14:0] TEMP_SCALE  = 15'd20000;
   localparam logic [14:0] TEMP_OFFSET = 15'd5000;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST_A,
      PH_ST_B,
      PH_WB_D,
      PH_WB_C,
      PH_WA_D,
      PH_WA_C,
      PH_RB_C,
      PH_RB_L,
      PH_RA_C,
      PH_SP_A,
      PH_SP_B,
      PH_SP_C,
      PH_WAIT
   } phase_type;

   typedef struct packed {
      logic [7:0]             half_period;
      logic [CONV_WAIT_W-1:0] conv_wait;
      logic [6:0]             dev_addr;
   } cfg_type;

   typedef struct packed {
      logic             scl_level;
      logic             sda_release;
      logic             busy;
      logic             done;
      logic             measure_ok;
      logic [RAW_W-1:0] humidity_raw;
      logic [RAW_W-1:0] temperature_raw;
   } step_res_type;

endpackage

// ===== src/humidity_sensor_i2c_reader_top.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_i2c_reader_top
// Each request transfer is one tick of a two-wire bus sequencer that talks to
// a humidity/temperature sensor. A tick carries the sampled SDA level and,
// while the block is idle, an optional command: init sends start, the write
// address, E1 08 00 and stop; measure sends start, the write address,
// AC 33 00 and stop, waits conversion_wait_ticks ticks, then reads six bytes
// (ACK on the first five, NACK on the last) and sends stop. Each bus phase
// holds for half_period_ticks ticks. Every request transfer yields exactly
// one response transfer with the SCL/SDA levels for that tick, busy and done
// flags, the last good raw readings and their values in hundredths. Rate:
// one tick per clock cycle while the response channel is not stalled; a
// request's result is captured in the stage-1 register, then passes the
// scaling multipliers into the output register. The user must write the
// registers through the csr port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module humidity_sensor_i2c_reader_top
   import hsi2c_pkg::*;
#(
   parameter int WAIT_BITS = WAIT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic                  req_sda_in,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_scl_level,
   output logic                  rsp_sda_release,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_measure_ok,
   output logic [RAW_W-1:0]      rsp_humidity_raw,
   output logic [RAW_W-1:0]      rsp_temperature_raw,
   output logic [13:0]           rsp_humidity_centi,
   output logic signed [14:0]    rsp_temperature_centi,
   // register write port
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   step_res_type step_res;
   step_res_type s1_res_ff;
   logic         s1_valid_ff, s1_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         s1_adv, s2_adv, req_xfer;
   logic [13:0]        hum_centi;
   logic signed [14:0] temp_centi;
   step_res_type       rsp_res_ff;
   logic [13:0]        rsp_hum_centi_ff;
   logic signed [14:0] rsp_temp_centi_ff;

   // ---------------------------------------------------------------------
   // Registers: new values apply when the sequencer enters its next phase
   // ---------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: cfg_in.half_period = csr_wdata[7:0];
            CSR_CONV_WAIT:   cfg_in.conv_wait   = csr_wdata[CONV_WAIT_W-1:0];
            CSR_DEV_ADDR:    cfg_in.dev_addr    = csr_wdata[6:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= HALF_PERIOD_RST;
         cfg_ff.conv_wait   <= CONV_WAIT_RST;
         cfg_ff.dev_addr    <= DEV_ADDR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Two-stage pipeline; each stage advances when it is empty or the stage
   // after it advances, so a held response never blocks an incoming tick
   // while the first stage has room.
   // ---------------------------------------------------------------------
   assign s2_adv    = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;
   assign req_xfer  = req_valid && req_ready;

   // Sequencer state advances only on a request transfer
   hsi2c_seq #(
      .WAIT_BITS (WAIT_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_xfer),
      .func    (req_func),
      .sda_in  (req_sda_in),
      .cfg     (cfg_ff),
      .res     (step_res)
   );

   assign s1_valid_in  = s1_adv ? req_xfer : s1_valid_ff;
   assign rsp_valid_in = s2_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage 1: capture the tick's levels and the updated readings
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_res_ff <= step_res;
      end
   end

   // Stage 2: scale the captured readings into the output register
   hsi2c_conv u_conv (
      .humidity_raw      (s1_res_ff.humidity_raw),
      .temperature_raw   (s1_res_ff.temperature_raw),
      .humidity_centi    (hum_centi),
      .temperature_centi (temp_centi)
   );

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_res_ff        <= s1_res_ff;
         rsp_hum_centi_ff  <= hum_centi;
         rsp_temp_centi_ff <= temp_centi;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_scl_level         = rsp_res_ff.scl_level;
   assign rsp_sda_release       = rsp_res_ff.sda_release;
   assign rsp_busy_res          = rsp_res_ff.busy;
   assign rsp_done_res          = rsp_res_ff.done;
   assign rsp_measure_ok        = rsp_res_ff.measure_ok;
   assign rsp_humidity_raw      = rsp_res_ff.humidity_raw;
   assign rsp_temperature_raw   = rsp_res_ff.temperature_raw;
   assign rsp_humidity_centi    = rsp_hum_centi_ff;
   assign rsp_temperature_centi = rsp_temp_centi_ff;

endmodule

// ===== src/hsi2c_seq.sv =====
// ----------------------------------------------------------------------------
// hsi2c_seq
// Tick-level bus sequencer: phase, counters, shift byte, received bytes and
// stored readings; advances one tick per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsi2c_seq
   import hsi2c_pkg::*;
#(
   parameter int WAIT_BITS = WAIT_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  logic [1:0]   func,
   input  logic         sda_in,
   input  cfg_type      cfg,
   output step_res_type res
);

   localparam int CNT_W  = (WAIT_BITS < CONV_WAIT_W) ? WAIT_BITS : CONV_WAIT_W;
   localparam int RX_IDX = $clog2(RX_BYTES);
   localparam logic [2:0] LAST_RX = 3'(RX_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic             kind_ff, kind_in;
   logic             reading_ff, reading_in;
   logic [2:0]       bit_ff, bit_in;
   logic [2:0]       byte_ff, byte_in;
   logic [CNT_W-1:0] wc_ff, wc_in;
   logic [7:0]       shift_ff, shift_in;
   logic [RAW_W-1:0] hum_ff, hum_in;
   logic [RAW_W-1:0] temp_ff, temp_in;
   logic             ok_ff, ok_in;
   logic [7:0]       rx_ff [RX_BYTES];
   logic             rx_we;
   logic [RX_IDX-1:0] rx_idx;

   logic [CNT_W-1:0] half_cnt;
   logic [CNT_W-1:0] wait_cnt;
   logic [CNT_W-1:0] wait_len;
   logic             scl_o, sda_o, busy_o, done_o;

   function automatic logic [7:0] wr_byte(logic [2:0] idx, logic rd, logic kind,
                                          logic [6:0] addr);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         3'd0:    b = {addr, rd};
         3'd1:    b = kind ? 8'hAC : 8'hE1;
         3'd2:    b = kind ? 8'h33 : 8'h08;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Zero-length phases last one tick
   assign half_cnt = (cfg.half_period == 8'd0) ? '0 : CNT_W'(cfg.half_period - 8'd1);
   assign wait_len = cfg.conv_wait[CNT_W-1:0];
   assign wait_cnt = (wait_len == '0) ? '0 : wait_len - CNT_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      reading_in = reading_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      wc_in      = wc_ff;
      shift_in   = shift_ff;
      hum_in     = hum_ff;
      temp_in    = temp_ff;
      ok_in      = ok_ff;
      rx_we      = 1'b0;
      rx_idx     = '0;
      scl_o      = 1'b1;
      sda_o      = 1'b1;
      busy_o     = 1'b0;
      done_o     = 1'b0;

      if (phase_ff == PH_IDLE && (func == FUNC_INIT || func == FUNC_MEASURE)) begin
         kind_in    = (func == FUNC_MEASURE);
         reading_in = 1'b0;
         phase_in   = PH_ST_A;
         wc_in      = half_cnt;
      end

      if (phase_in != PH_IDLE) begin
         busy_o = 1'b1;
         case (phase_in)
            PH_ST_B: begin scl_o = 1'b1; sda_o = 1'b0; end
            PH_WB_D: begin scl_o = 1'b0; sda_o = shift_in[7]; end
            PH_WB_C: begin scl_o = 1'b1; sda_o = shift_in[7]; end
            PH_WA_D: begin scl_o = 1'b0; sda_o = 1'b1; end
            PH_RB_L: begin scl_o = 1'b0; sda_o = 1'b1; end
            PH_RA_C: begin scl_o = 1'b1; sda_o = (byte_in < 3'd5) ? 1'b0 : 1'b1; end
            PH_SP_A: begin scl_o = 1'b0; sda_o = 1'b0; end
            PH_SP_B: begin scl_o = 1'b1; sda_o = 1'b0; end
            default: begin scl_o = 1'b1; sda_o = 1'b1; end
         endcase

         if (wc_in != '0) begin
            wc_in = wc_in - CNT_W'(1);
         end else begin
            wc_in = half_cnt;
            unique case (phase_in)
               PH_ST_A: phase_in = PH_ST_B;
               PH_ST_B: begin
                  byte_in  = 3'd0;
                  bit_in   = 3'd0;
                  shift_in = wr_byte(3'd0, reading_in, kind_in, cfg.dev_addr);
                  phase_in = PH_WB_D;
               end
               PH_WB_D: phase_in = PH_WB_C;
               PH_WB_C: begin
                  if (bit_in == 3'd7) begin
                     phase_in = PH_WA_D;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     shift_in = {shift_in[6:0], 1'b0};
                     phase_in = PH_WB_D;
                  end
               end
               PH_WA_D: phase_in = PH_WA_C;
               PH_WA_C: begin
                  bit_in = 3'd0;
                  if (reading_in) begin
                     byte_in  = 3'd0;
                     shift_in = 8'h00;
                     phase_in = PH_RB_C;
                  end else if (byte_in >= 3'd3) begin
                     phase_in = PH_SP_A;
                  end else begin
                     byte_in  = byte_in + 3'd1;
                     shift_in = wr_byte(byte_in, reading_in, kind_in, cfg.dev_addr);
                     phase_in = PH_WB_D;
                  end
               end
               PH_RB_C: begin
                  shift_in = {shift_in[6:0], sda_in};
                  phase_in = PH_RB_L;
               end
               PH_RB_L: begin
                  if (bit_in == 3'd7) begin
                     rx_we    = 1'b1;
                     rx_idx   = RX_IDX'((byte_in < 3'(RX_BYTES)) ? byte_in : LAST_RX);
                     phase_in = PH_RA_C;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = PH_RB_C;
                  end
               end
               PH_RA_C: begin
                  if (byte_in >= 3'd5) begin
                     phase_in = PH_SP_A;
                  end else begin
                     byte_in  = byte_in + 3'd1;
                     bit_in   = 3'd0;
                     shift_in = 8'h00;
                     phase_in = PH_RB_C;
                  end
               end
               PH_SP_A: phase_in = PH_SP_B;
               PH_SP_B: phase_in = PH_SP_C;
               PH_SP_C: begin
                  if (kind_in && !reading_in) begin
                     reading_in = 1'b1;
                     phase_in   = PH_WAIT;
                     wc_in      = wait_cnt;
                  end else begin
                     if (reading_in) begin
                        if (rx_ff[0][7]) begin
                           ok_in = 1'b0;
                        end else begin
                           hum_in  = {rx_ff[1], rx_ff[2], rx_ff[3][7:4]};
                           temp_in = {rx_ff[3][3:0], rx_ff[4], rx_ff[5]};
                           ok_in   = 1'b1;
                        end
                     end
                     reading_in = 1'b0;
                     phase_in   = PH_IDLE;
                     wc_in      = '0;
                     done_o     = 1'b1;
                  end
               end
               PH_WAIT: phase_in = PH_ST_A;
               default: begin
                  phase_in   = PH_IDLE;
                  wc_in      = '0;
                  reading_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         kind_ff    <= 1'b0;
         reading_ff <= 1'b0;
         bit_ff     <= '0;
         byte_ff    <= '0;
         wc_ff      <= '0;
         shift_ff   <= '0;
         hum_ff     <= '0;
         temp_ff    <= '0;
         ok_ff      <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         reading_ff <= reading_in;
         bit_ff     <= bit_in;
         byte_ff    <= byte_in;
         wc_ff      <= wc_in;
         shift_ff   <= shift_in;
         hum_ff     <= hum_in;
         temp_ff    <= temp_in;
         ok_ff      <= ok_in;
      end
   end

   // Received bytes hold no reset
   always_ff @(posedge clock) begin
      if (step_en && rx_we) begin
         rx_ff[rx_idx] <= shift_in;
      end
   end

   assign res.scl_level       = scl_o;
   assign res.sda_release     = sda_o;
   assign res.busy            = busy_o;
   assign res.done            = done_o;
   assign res.measure_ok      = ok_in;
   assign res.humidity_raw    = hum_in;
   assign res.temperature_raw = temp_in;

endmodule

// ===== src/hsi2c_conv.sv =====
// ----------------------------------------------------------------------------
// hsi2c_conv
// Fixed-point scaling of raw readings to hundredths of percent and degrees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsi2c_conv
   import hsi2c_pkg::*;
(
   input  logic [RAW_W-1:0]   humidity_raw,
   input  logic [RAW_W-1:0]   temperature_raw,
   output logic [13:0]        humidity_centi,
   output logic signed [14:0] temperature_centi
);

   localparam int HP_W = RAW_W + 14;
   localparam int TP_W = RAW_W + 15;

   logic [HP_W-1:0] hum_prod;
   logic [TP_W-1:0] temp_prod;
   logic [14:0]     temp_scaled;

   // Multiply, truncate the fraction, then drop the temperature offset
   assign hum_prod          = HP_W'(humidity_raw) * HP_W'(HUM_SCALE);
   assign temp_prod         = TP_W'(temperature_raw) * TP_W'(TEMP_SCALE);
   assign humidity_centi    = hum_prod[HP_W-1:FRAC_BITS];
   assign temp_scaled       = temp_prod[TP_W-1:FRAC_BITS];
   assign temperature_centi = $signed(temp_scaled - TEMP_OFFSET);

endmodule

// ===== src/hsi2c_chk.sv =====
// ----------------------------------------------------------------------------
// hsi2c_chk
// Port-level checks on the response stream of the humidity sensor bus reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "humidity_sensor_i2c_reader_top_defines.svh"

module hsi2c_chk
   import hsi2c_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_scl_level,
   input logic               rsp_sda_release,
   input logic               rsp_busy_res,
   input logic               rsp_done_res,
   input logic [RAW_W-1:0]   rsp_humidity_raw,
   input logic [13:0]        rsp_humidity_centi,
   input logic signed [14:0] rsp_temperature_centi
);

   // A finishing tick always belongs to a sequence
   `HSI2C_ASSERT_NOW(a_done_busy, rsp_valid && rsp_done_res, rsp_busy_res, "done without busy")

   // Idle ticks release both bus lines
   `HSI2C_ASSERT_NOW(a_idle_lines, rsp_valid && !rsp_busy_res, rsp_scl_level && rsp_sda_release, "idle drives bus")

   // Scaled values stay within the sensor's range
   `HSI2C_ASSERT_NOW(a_ranges, rsp_valid, (rsp_humidity_centi <= 14'd9999) && (rsp_temperature_centi >= -15'sd5000), "scaled value out of range")

   // A stalled response holds
   `HSI2C_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_humidity_raw), "stalled response changed")

endmodule

bind humidity_sensor_i2c_reader_top hsi2c_chk u_chk (.*);
